### rtl/core/smpq_pkg.sv
// Shared types and codes for the sorted min-first priority queue.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int TOTAL_W = 5;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // Status codes carried by a response
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_RESERVED = 2'd3
  } status_t;

  // One stored entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_cmd_t;

endpackage
`default_nettype wire

### rtl/core/smpq_req_if.sv
// Request channel: valid/ready handshake with push, pop or peek payload.
`timescale 1ns / 1ps
`default_nettype none

interface smpq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [smpq_pkg::VALUE_W-1:0] item_value;
  logic signed [smpq_pkg::PRIO_W-1:0]  item_priority;

  modport source (output valid, output mode, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input mode, input item_value, input item_priority,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/smpq_rsp_if.sv
// Response channel: valid/ready handshake with value, status and occupancy.
`timescale 1ns / 1ps
`default_nettype none

interface smpq_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [smpq_pkg::VALUE_W-1:0] out_value;
  logic [1:0]  status;
  logic [smpq_pkg::TOTAL_W-1:0] entry_total;
  logic        is_empty;

  modport source (output valid, output out_value, output status, output entry_total,
                  output is_empty, input ready);
  modport sink   (input valid, input out_value, input status, input entry_total,
                  input is_empty, output ready);
endinterface
`default_nettype wire

### rtl/core/smpq_cell.sv
// One storage cell of the sorted chain: holds, takes the new item, or shifts.
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  wire                    clk,
  input  smpq_pkg::cell_cmd_t    cmd,
  input  wire  [CW-1:0]          count,
  input  wire                    left_ins,
  input  smpq_pkg::entry_t       left,
  input  smpq_pkg::entry_t       right,
  output smpq_pkg::entry_t       entry,
  output logic                   ins
);

  logic occupied;

  // Flag this cell as at or past the insertion point
  assign occupied = count > CW'(INDEX);
  assign ins      = !occupied || (entry.prio >= cmd.item.prio);

  // Take the left neighbor past the insertion point, the new item at it, or
  // the right neighbor on a pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (left_ins) begin
        entry <= left;
      end else if (ins) begin
        entry <= cmd.item;
      end
    end else if (cmd.pop) begin
      entry <= right;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sorted_min_priority_queue.sv
// Top level of the sorted min-first priority queue built as a chain of cells.
//
//   channel | dir | payload                                    | accepted when
//   req     | in  | mode, item_value, item_priority            | valid && ready
//   rsp     | out | out_value, status, entry_total, is_empty   | valid && ready
//
// For each request every cell compares its priority with the new item in
// parallel and shifts in one step, and the response is registered.
// A new request is taken whenever the response register is empty or drains.
// Synchronous active-high reset empties the queue and the response register.
// Cell contents are never reset; only cells below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_min_priority_queue #(
  parameter int CAPACITY = 16
) (
  input wire          clk,
  input wire          rst,
  smpq_req_if.sink    req,
  smpq_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = smpq_pkg::TOTAL_W;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                fire;
  logic                full;
  logic                empty;
  smpq_pkg::mode_t     mode;
  smpq_pkg::cell_cmd_t cmd;
  smpq_pkg::entry_t    cell_entry [CAPACITY];
  logic                cell_ins   [CAPACITY];
  smpq_pkg::status_t   status_next;
  logic signed [smpq_pkg::VALUE_W-1:0] value_next;
  logic [TW+CW-1:0]    total_wide;

  assign mode  = smpq_pkg::mode_t'(req.mode);
  assign fire  = req.valid && req.ready;
  assign full  = count == CW'(CAPACITY);
  assign empty = count == '0;

  // Accept while the response register is free or being drained
  assign req.ready = !rsp.valid || rsp.ready;

  // Decode the request into the cell command and the response
  always_comb begin
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.item.value = req.item_value;
    cmd.item.prio  = req.item_priority;
    count_next     = count;
    status_next    = smpq_pkg::STATUS_OK;
    value_next     = '0;
    unique case (mode)
      smpq_pkg::MODE_PUSH: begin
        if (full) begin
          status_next = smpq_pkg::STATUS_FULL;
        end else begin
          cmd.push   = fire;
          count_next = count + 1'b1;
        end
      end
      smpq_pkg::MODE_POP, smpq_pkg::MODE_PEEK: begin
        if (empty) begin
          status_next = smpq_pkg::STATUS_EMPTY;
        end else begin
          value_next = cell_entry[0].value;
          if (mode == smpq_pkg::MODE_POP) begin
            cmd.pop    = fire;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             left_ins;
    smpq_pkg::entry_t left;
    smpq_pkg::entry_t right;

    if (i == 0) begin : g_first
      assign left_ins = 1'b0;
      assign left     = cmd.item;
    end else begin : g_mid
      assign left_ins = cell_ins[i-1];
      assign left     = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    smpq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count),
      .left_ins (left_ins),
      .left     (left),
      .right    (right),
      .entry    (cell_entry[i]),
      .ins      (cell_ins[i])
    );
  end

  // Advance the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  assign total_wide = {{TW{1'b0}}, count_next};

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.out_value   <= value_next;
      rsp.status      <= status_next;
      rsp.entry_total <= total_wide[TW-1:0];
      rsp.is_empty    <= count_next == '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_shrinks : assert property (@(posedge clk) disable iff (rst)
    fire && mode == smpq_pkg::MODE_POP && !empty |=> count == $past(count) - 1'b1)
    else $error("pop did not remove one entry");

  a_full_drop : assert property (@(posedge clk) disable iff (rst)
    fire && mode == smpq_pkg::MODE_PUSH && full |=>
      rsp.status == smpq_pkg::STATUS_FULL && rsp.out_value == '0 && $stable(count))
    else $error("push to full queue not dropped");

  a_empty_total : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.is_empty |-> rsp.entry_total == '0)
    else $error("empty flag with nonzero total");
`endif

endmodule
`default_nettype wire
